FILE: sv/assert_macros.svh
// Assertion helpers for the RTL files, included by the queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define SGM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sgm assertion failed");

// Checks that a condition never holds at a clock edge outside reset.
`define SGM_NEVER(label, clk, rst_n, cond) \
    `SGM_ASSERT(label, clk, rst_n, !(cond))

`endif

FILE: sv/sgm_pkg.sv
package sgm_pkg;

    // Gray value is (r+g+b)/3, done as multiply by a reciprocal and a shift.
    localparam int GRAY_RECIP = 683;
    localparam int GRAY_SHIFT = 11;

    localparam int QUEUE_DEPTH = 2;

    localparam int HEIGHT_MAX = 1024;
    localparam int CFG_W      = 11;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    // Root iterations: one result bit per cycle for a 21-bit radicand.
    localparam int ROOT_STEPS = 11;
    localparam int SQ_W       = 21;

    // Window snapshot handed from the front to the back.
    typedef struct packed {
        logic [7:0] w00;
        logic [7:0] w01;
        logic [7:0] w02;
        logic [7:0] w10;
        logic [7:0] w12;
        logic [7:0] w20;
        logic [7:0] w21;
        logic [7:0] w22;
        logic       last;
    } sgm_entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } sgm_qstat_t;

    typedef enum logic {
        F_IDLE,
        F_PROC
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GRAD,
        B_SQ,
        B_ROOT,
        B_OUT
    } back_state_t;

endpackage

FILE: sv/sgm_front.sv
module sgm_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic               drain,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  sgm_pkg::sgm_qstat_t qstat,
    output logic               push,
    output sgm_pkg::sgm_entry_t push_entry
);
    import sgm_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    front_state_t state_reg, state_next;
    logic [10:0]   fw_reg, fh_reg;
    logic [AW-1:0] col_reg;
    logic [10:0]   row_reg;
    logic [7:0]    gray_reg;
    logic [15:0]   rd_reg;
    logic [7:0]    win_reg [0:2][0:2];
    logic [15:0]   mem [0:MAX_WIDTH-1];

    logic [CW-1:0] eff_w;
    logic [10:0]   eff_h;
    logic [AW-1:0] col_eff;
    logic          pixel_row;
    logic [9:0]    rgb_sum;
    logic [19:0]   gray_prod;
    logic          accept;
    logic [7:0]    top, mid, bot;
    logic [CW-1:0] col_inc;

    // Effective frame size, saturated to the legal range.
    always_comb
    begin
        if ({{(CW-CFG_W){1'b0}}, fw_reg} < CW'(2))
            eff_w = CW'(2);
        else if ({{(CW-CFG_W){1'b0}}, fw_reg} > CW'(MAX_WIDTH))
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = {{(CW-CFG_W){1'b0}}, fw_reg};
        if (fh_reg < 11'd2)
            eff_h = 11'd2;
        else if (fh_reg > 11'(HEIGHT_MAX))
            eff_h = 11'(HEIGHT_MAX);
        else
            eff_h = fh_reg;
    end

    assign col_eff   = ({{(CW-AW){1'b0}}, col_reg} >= eff_w) ? '0 : col_reg;
    assign pixel_row = row_reg < eff_h;
    assign rgb_sum   = 10'(red) + 10'(green) + 10'(blue);
    assign gray_prod = 20'(rgb_sum) * 20'(GRAY_RECIP);
    assign in_ready  = (state_reg == F_IDLE) && !qstat.full;
    assign accept    = in_valid && in_ready;
    assign col_inc   = {{(CW-AW){1'b0}}, col_eff} + CW'(1);

    // Column sources for the window.
    always_comb
    begin
        mid = (row_reg >= 11'd1) ? rd_reg[7:0] : gray_reg;
        top = (row_reg >= 11'd2) ? rd_reg[15:8] : mid;
        bot = pixel_row ? gray_reg : mid;
    end

    // Next state and the push toward the queue.
    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        push_entry = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && !(drain && pixel_row))
                    state_next = F_PROC;
            end
            F_PROC:
            begin
                state_next = F_IDLE;
                push_entry.w00 = win_reg[0][1];
                push_entry.w10 = win_reg[1][1];
                push_entry.w20 = win_reg[2][1];
                push_entry.w01 = win_reg[0][2];
                push_entry.w21 = win_reg[2][2];
                if (col_eff == '0)
                begin
                    push_entry.w02  = win_reg[0][2];
                    push_entry.w12  = win_reg[1][2];
                    push_entry.w22  = win_reg[2][2];
                    push_entry.last = (row_reg == eff_h + 11'd1);
                    push            = (row_reg >= 11'd2);
                end
                else
                begin
                    push_entry.w02  = top;
                    push_entry.w12  = mid;
                    push_entry.w22  = bot;
                    push_entry.last = 1'b0;
                    push            = (row_reg >= 11'd1);
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration and frame position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= 11'd481;
            fh_reg  <= 11'd321;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_valid && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                fw_reg <= cfg_data;
            else
                fh_reg <= cfg_data;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (state_reg == F_PROC)
        begin
            if (row_reg >= eff_h + 11'd1)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_inc >= eff_w)
            begin
                col_reg <= '0;
                row_reg <= row_reg + 11'd1;
            end
            else
                col_reg <= col_inc[AW-1:0];
        end
    end

    // Line store pair: upper in the high byte, lower in the low byte.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg   <= mem[col_eff];
            gray_reg <= pixel_row ? gray_prod[GRAY_SHIFT+7:GRAY_SHIFT] : 8'd0;
        end
        if (state_reg == F_PROC && pixel_row)
            mem[col_eff] <= {rd_reg[7:0], gray_reg};
    end

    // Sliding window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= 8'd0;
        end
        else if (state_reg == F_PROC)
        begin
            if (col_eff == '0)
            begin
                win_reg[0][0] <= win_reg[0][1];
                win_reg[1][0] <= win_reg[1][1];
                win_reg[2][0] <= win_reg[2][1];
                win_reg[0][1] <= top;
                win_reg[0][2] <= top;
                win_reg[1][1] <= mid;
                win_reg[1][2] <= mid;
                win_reg[2][1] <= bot;
                win_reg[2][2] <= bot;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= top;
                win_reg[1][2] <= mid;
                win_reg[2][2] <= bot;
            end
        end
    end

endmodule

FILE: sv/sgm_queue.sv
`include "assert_macros.svh"

module sgm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sgm_pkg::sgm_entry_t push_entry,
    input  logic                pop,
    output sgm_pkg::sgm_entry_t pop_entry,
    output sgm_pkg::sgm_qstat_t qstat
);
    import sgm_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    sgm_entry_t     slot_reg [0:QUEUE_DEPTH-1];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [PW:0]    count_reg;

    assign qstat.full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_entry   = slot_reg[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + PW'(1);
            if (pop)
                rd_reg <= rd_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

    `SGM_NEVER(a_no_overflow, clk, rst_n, push && qstat.full)
    `SGM_NEVER(a_no_underflow, clk, rst_n, pop && qstat.empty)
    `SGM_ASSERT(a_count_range, clk, rst_n, count_reg <= (PW+1)'(QUEUE_DEPTH))

endmodule

FILE: sv/sgm_back.sv
module sgm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sgm_pkg::sgm_qstat_t qstat,
    input  sgm_pkg::sgm_entry_t pop_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [10:0]         magnitude,
    output logic signed [10:0]  grad_x,
    output logic signed [10:0]  grad_y,
    output logic                frame_last
);
    import sgm_pkg::*;

    back_state_t       state_reg, state_next;
    logic signed [10:0] gx_reg, gy_reg;
    logic [9:0]        ax_reg, ay_reg;
    logic              last_reg;
    logic [SQ_W-1:0]   v_reg, res_reg, bit_reg;
    logic [3:0]        step_reg, step_next;

    logic [9:0]        sl, sr, st, sb;
    logic signed [10:0] gx, gy;
    logic [SQ_W-1:0]   trial;

    // Weighted column and row sums of the window.
    always_comb
    begin
        sl = 10'(pop_entry.w00) + {1'b0, pop_entry.w10, 1'b0} + 10'(pop_entry.w20);
        sr = 10'(pop_entry.w02) + {1'b0, pop_entry.w12, 1'b0} + 10'(pop_entry.w22);
        st = 10'(pop_entry.w00) + {1'b0, pop_entry.w01, 1'b0} + 10'(pop_entry.w02);
        sb = 10'(pop_entry.w20) + {1'b0, pop_entry.w21, 1'b0} + 10'(pop_entry.w22);
        gx = $signed({1'b0, sr}) - $signed({1'b0, sl});
        gy = $signed({1'b0, st}) - $signed({1'b0, sb});
    end

    assign pop        = (state_reg == B_IDLE) && !qstat.empty;
    assign trial      = res_reg + bit_reg;
    assign out_valid  = (state_reg == B_OUT);
    assign magnitude  = res_reg[10:0];
    assign grad_x     = gx_reg;
    assign grad_y     = gy_reg;
    assign frame_last = last_reg;

    // Sequencer: gradients, squares, one root bit per cycle, then output.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                    state_next = B_GRAD;
            end
            B_GRAD: state_next = B_SQ;
            B_SQ:
            begin
                state_next = B_ROOT;
                step_next  = '0;
            end
            B_ROOT:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(ROOT_STEPS - 1))
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_ready)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                gx_reg   <= gx;
                gy_reg   <= gy;
                last_reg <= pop_entry.last;
            end
            B_GRAD:
            begin
                ax_reg <= gx_reg[10] ? 10'(-gx_reg) : gx_reg[9:0];
                ay_reg <= gy_reg[10] ? 10'(-gy_reg) : gy_reg[9:0];
            end
            B_SQ:
            begin
                v_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg) + SQ_W'(ay_reg) * SQ_W'(ay_reg);
                res_reg <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 1);
            end
            B_ROOT:
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            B_OUT: ;
            default: ;
        endcase
    end

endmodule

FILE: sv/sobel_gradient_magnitude_top.sv
// Sobel gradient magnitude over an RGB raster, one item in flight in the front.
// Front: an accepted item gets a line store read, then a window update, and no
// new item is taken meanwhile. Back: each result passes gradients, squares,
// 11 root iterations and output; the back pops no new window until the last
// result has been taken, so the square root and out_ready set the sustained rate.
// Asynchronous active-low reset clears counters, window and queue; line stores
// are not cleared and hold undefined data until written.
module sobel_gradient_magnitude_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic               drain,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [10:0]        magnitude,
    output logic signed [10:0] grad_x,
    output logic signed [10:0] grad_y,
    output logic               frame_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data
);
    import sgm_pkg::*;

    sgm_qstat_t qstat;
    sgm_entry_t push_entry, pop_entry;
    logic       push, pop;

    assign cfg_ready = 1'b1;

    // Front: pixel intake, line stores and window.
    sgm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .red(red), .green(green), .blue(blue), .drain(drain),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .qstat(qstat), .push(push), .push_entry(push_entry)
    );

    // Queue between front and back.
    sgm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_entry(push_entry),
        .pop(pop), .pop_entry(pop_entry), .qstat(qstat)
    );

    // Back: gradients and magnitude.
    sgm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .qstat(qstat), .pop_entry(pop_entry), .pop(pop),
        .out_valid(out_valid), .out_ready(out_ready),
        .magnitude(magnitude), .grad_x(grad_x), .grad_y(grad_y),
        .frame_last(frame_last)
    );

endmodule
